// File: rtl/sit_pkg.sv
package sit_pkg;

   // Coordinate width sets the transfer structs below; every other width follows.
   localparam int COORD_WIDTH = 16;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
   localparam int CROSS_WIDTH = PROD_WIDTH + 1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [CROSS_WIDTH-1:0] cross_type;

   typedef enum logic [1:0] {
      ORIENT_COLINEAR = 2'd0,
      ORIENT_CW       = 2'd1,
      ORIENT_CCW      = 2'd2
   } orient_type;

   typedef struct packed {
      coord_type a_start_x;
      coord_type a_start_y;
      coord_type a_end_x;
      coord_type a_end_y;
      coord_type b_start_x;
      coord_type b_start_y;
      coord_type b_end_x;
      coord_type b_end_y;
   } req_type;

   typedef struct packed {
      logic crossing;
      logic direction_down;
   } rsp_type;

   // Bit k of box flags the colinear case of orientation k+1.
   typedef logic [3:0] box_type;

   typedef struct packed {
      diff_type a_dx;
      diff_type a_dy;
      diff_type b_dx;
      diff_type b_dy;
      diff_type bs_aex;
      diff_type bs_aey;
      diff_type be_aex;
      diff_type be_aey;
      diff_type as_bex;
      diff_type as_bey;
      diff_type ae_bex;
      diff_type ae_bey;
      box_type  box;
   } diff_stage_type;

   typedef struct packed {
      prod_type o1_lhs;
      prod_type o1_rhs;
      prod_type o2_lhs;
      prod_type o2_rhs;
      prod_type o3_lhs;
      prod_type o3_rhs;
      prod_type o4_lhs;
      prod_type o4_rhs;
      box_type  box;
   } prod_stage_type;

   typedef struct packed {
      orient_type o1;
      orient_type o2;
      orient_type o3;
      orient_type o4;
      box_type    box;
   } orient_stage_type;

endpackage

// File: rtl/sit_diff.sv
module sit_diff (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  sit_pkg::req_type        in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output sit_pkg::diff_stage_type out_data
);
   import sit_pkg::*;

   logic           valid_ff;
   diff_stage_type data_ff;
   diff_stage_type data_in;

   // q inside the closed bounding box of segment p-r
   function automatic logic in_box(coord_type px, coord_type py, coord_type qx,
                                   coord_type qy, coord_type rx, coord_type ry);
      logic in_x;
      logic in_y;
      in_x = (qx <= px || qx <= rx) && (qx >= px || qx >= rx);
      in_y = (qy <= py || qy <= ry) && (qy >= py || qy >= ry);
      return in_x && in_y;
   endfunction

   function automatic diff_type sub(coord_type a, coord_type b);
      return diff_type'(a) - diff_type'(b);
   endfunction

   always_comb begin
      data_in.a_dx   = sub(in_data.a_end_x,   in_data.a_start_x);
      data_in.a_dy   = sub(in_data.a_end_y,   in_data.a_start_y);
      data_in.b_dx   = sub(in_data.b_end_x,   in_data.b_start_x);
      data_in.b_dy   = sub(in_data.b_end_y,   in_data.b_start_y);
      data_in.bs_aex = sub(in_data.b_start_x, in_data.a_end_x);
      data_in.bs_aey = sub(in_data.b_start_y, in_data.a_end_y);
      data_in.be_aex = sub(in_data.b_end_x,   in_data.a_end_x);
      data_in.be_aey = sub(in_data.b_end_y,   in_data.a_end_y);
      data_in.as_bex = sub(in_data.a_start_x, in_data.b_end_x);
      data_in.as_bey = sub(in_data.a_start_y, in_data.b_end_y);
      data_in.ae_bex = sub(in_data.a_end_x,   in_data.b_end_x);
      data_in.ae_bey = sub(in_data.a_end_y,   in_data.b_end_y);
      data_in.box[0] = in_box(in_data.a_start_x, in_data.a_start_y,
                              in_data.b_start_x, in_data.b_start_y,
                              in_data.a_end_x,   in_data.a_end_y);
      data_in.box[1] = in_box(in_data.a_start_x, in_data.a_start_y,
                              in_data.b_end_x,   in_data.b_end_y,
                              in_data.a_end_x,   in_data.a_end_y);
      data_in.box[2] = in_box(in_data.b_start_x, in_data.b_start_y,
                              in_data.a_start_x, in_data.a_start_y,
                              in_data.b_end_x,   in_data.b_end_y);
      data_in.box[3] = in_box(in_data.b_start_x, in_data.b_start_y,
                              in_data.a_end_x,   in_data.a_end_y,
                              in_data.b_end_x,   in_data.b_end_y);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// File: rtl/sit_cross.sv
module sit_cross (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  sit_pkg::diff_stage_type in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output sit_pkg::prod_stage_type out_data
);
   import sit_pkg::*;

   logic           valid_ff;
   prod_stage_type data_ff;
   prod_stage_type data_in;

   function automatic prod_type mul(diff_type a, diff_type b);
      return prod_type'(a) * prod_type'(b);
   endfunction

   always_comb begin
      data_in.o1_lhs = mul(in_data.a_dy, in_data.bs_aex);
      data_in.o1_rhs = mul(in_data.a_dx, in_data.bs_aey);
      data_in.o2_lhs = mul(in_data.a_dy, in_data.be_aex);
      data_in.o2_rhs = mul(in_data.a_dx, in_data.be_aey);
      data_in.o3_lhs = mul(in_data.b_dy, in_data.as_bex);
      data_in.o3_rhs = mul(in_data.b_dx, in_data.as_bey);
      data_in.o4_lhs = mul(in_data.b_dy, in_data.ae_bex);
      data_in.o4_rhs = mul(in_data.b_dx, in_data.ae_bey);
      data_in.box    = in_data.box;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// File: rtl/sit_orient.sv
module sit_orient (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  sit_pkg::prod_stage_type   in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output sit_pkg::orient_stage_type out_data
);
   import sit_pkg::*;

   logic             valid_ff;
   orient_stage_type data_ff;
   orient_stage_type data_in;

   function automatic orient_type orient_of(prod_type lhs, prod_type rhs);
      cross_type val;
      orient_type code;
      val = cross_type'(lhs) - cross_type'(rhs);
      if (val == '0) begin
         code = ORIENT_COLINEAR;
      end else if (val[CROSS_WIDTH-1]) begin
         code = ORIENT_CCW;
      end else begin
         code = ORIENT_CW;
      end
      return code;
   endfunction

   always_comb begin
      data_in.o1  = orient_of(in_data.o1_lhs, in_data.o1_rhs);
      data_in.o2  = orient_of(in_data.o2_lhs, in_data.o2_rhs);
      data_in.o3  = orient_of(in_data.o3_lhs, in_data.o3_rhs);
      data_in.o4  = orient_of(in_data.o4_lhs, in_data.o4_rhs);
      data_in.box = in_data.box;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// File: rtl/segment_intersection_test_unit.sv
// Segment intersection test. Each req transfer carries two segments A and B as
// signed 16-bit endpoint coordinates; each rsp transfer carries one result:
// crossing (the segments touch or intersect, including colinear overlap and
// degenerate point segments) and direction_down (A's start lies counterclockwise
// of B, given whatever crossing says). One pair enters per clock and results
// leave in order, one per clock, when nothing stalls. There are four register
// stages: endpoint differences and bounding-box compares, the eight 17x17
// cross-product multipliers, the wide subtract that turns each cross product
// into an orientation code, and the output register that combines the four
// codes. Cross products are exact at full width. Every stage has its own valid
// bit, so bubbles close up under rsp_ready backpressure and nothing is dropped
// or repeated.
module segment_intersection_test_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sit_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sit_pkg::rsp_type rsp_data
);
   import sit_pkg::*;

   logic             diff_valid;
   logic             diff_ready;
   diff_stage_type   diff_data;
   logic             prod_valid;
   logic             prod_ready;
   prod_stage_type   prod_data;
   logic             orient_valid;
   logic             orient_ready;
   orient_stage_type orient_data;

   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;
   rsp_type          rsp_data_in;

   // Stage 1: differences and bounding-box compares.
   sit_diff u_diff (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (diff_valid),
      .out_ready (diff_ready),
      .out_data  (diff_data)
   );

   // Stage 2: cross-product terms.
   sit_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (diff_valid),
      .in_ready  (diff_ready),
      .in_data   (diff_data),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_data  (prod_data)
   );

   // Stage 3: orientation codes.
   sit_orient u_orient (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_data   (prod_data),
      .out_valid (orient_valid),
      .out_ready (orient_ready),
      .out_data  (orient_data)
   );

   // Stage 4: general case, else any colinear orientation whose point is boxed.
   always_comb begin
      rsp_data_in.crossing =
         ((orient_data.o1 != orient_data.o2) && (orient_data.o3 != orient_data.o4)) ||
         ((orient_data.o1 == ORIENT_COLINEAR) && orient_data.box[0]) ||
         ((orient_data.o2 == ORIENT_COLINEAR) && orient_data.box[1]) ||
         ((orient_data.o3 == ORIENT_COLINEAR) && orient_data.box[2]) ||
         ((orient_data.o4 == ORIENT_COLINEAR) && orient_data.box[3]);
      rsp_data_in.direction_down = (orient_data.o3 == ORIENT_CCW);
   end

   // Hold the result until the rsp transfer; refill while it drains.
   assign orient_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (orient_ready) begin
         rsp_valid_ff <= orient_valid;
      end
      if (orient_ready && orient_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// File: rtl/sit_checker.sv
module sit_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sit_pkg::rsp_type rsp_data
);

   // Reset empties the result register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // An empty output means every stage can advance, so a request can be taken.
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("req_ready low with empty output");

   // With no backpressure a request passes the difference, cross and orientation registers into the output.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("request lost in pipeline");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp changed");

endmodule

bind segment_intersection_test_unit sit_checker u_sit_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: sim/tb_segment_intersection_test_unit.sv
module tb_segment_intersection_test_unit;

   timeunit 1ns;
   timeprecision 1ps;

   import sit_pkg::*;

   localparam int CLOCK_HALF    = 4;
   localparam int RESET_CYCLES  = 7;
   localparam int RANDOM_PHASE  = 890;
   localparam int SETTLE_CYCLES = 20;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_CYCLES   = 200;
   localparam int HOLD_SPACING  = 500;

   // receiver stall patterns
   typedef enum logic [1:0] {
      RX_OPEN   = 2'd0,
      RX_MOSTLY = 2'd1,
      RX_SPARSE = 2'd2,
      RX_TOGGLE = 2'd3
   } rx_mode_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // segment pairs waiting for the driver, and the verdicts owed by the block
   req_type pair_q[$];
   rsp_type verdict_q[$];

   int      pairs_queued   = 0;
   int      pairs_taken    = 0;
   int      verdicts_seen  = 0;
   int      mismatch_count = 0;
   int      cycle_count    = 0;
   logic    req_taken      = 1'b0;
   rsp_type verdict_head;

   // driver pacing
   int      burst_left = 1;
   int      gap_left   = 0;

   // receiver pacing
   rx_mode_type rx_mode      = RX_OPEN;
   int          stretch_left = 0;
   int          hold_left    = 0;
   int          holds_done   = 0;

   segment_intersection_test_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor: exact cross products in 64 bits, no state.
   // ------------------------------------------------------------------

   // Turn of r as seen walking from p to q.
   function automatic orient_type turn_of(longint px, longint py, longint qx, longint qy,
                                          longint rx, longint ry);
      longint cross_val;
      cross_val = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
      if (cross_val == 0) return ORIENT_COLINEAR;
      if (cross_val > 0) return ORIENT_CW;
      return ORIENT_CCW;
   endfunction

   // q inside the closed bounding box spanned by p and r
   function automatic bit within_box(longint px, longint py, longint qx, longint qy,
                                     longint rx, longint ry);
      return (qx <= ((px > rx) ? px : rx)) && (qx >= ((px < rx) ? px : rx)) &&
             (qy <= ((py > ry) ? py : ry)) && (qy >= ((py < ry) ? py : ry));
   endfunction

   function automatic rsp_type judge_segments(req_type pair);
      longint     ax, ay, aex, aey, bx, by, bex, bey;
      orient_type t1, t2, t3, t4;
      rsp_type    verdict;
      // signed fields sign-extend on assignment
      ax  = pair.a_start_x;
      ay  = pair.a_start_y;
      aex = pair.a_end_x;
      aey = pair.a_end_y;
      bx  = pair.b_start_x;
      by  = pair.b_start_y;
      bex = pair.b_end_x;
      bey = pair.b_end_y;
      t1 = turn_of(ax, ay, aex, aey, bx, by);
      t2 = turn_of(ax, ay, aex, aey, bex, bey);
      t3 = turn_of(bx, by, bex, bey, ax, ay);
      t4 = turn_of(bx, by, bex, bey, aex, aey);
      verdict.crossing =
         (t1 != t2 && t3 != t4) ||
         (t1 == ORIENT_COLINEAR && within_box(ax, ay, bx, by, aex, aey)) ||
         (t2 == ORIENT_COLINEAR && within_box(ax, ay, bex, bey, aex, aey)) ||
         (t3 == ORIENT_COLINEAR && within_box(bx, by, ax, ay, bex, bey)) ||
         (t4 == ORIENT_COLINEAR && within_box(bx, by, aex, aey, bex, bey));
      verdict.direction_down = (t3 == ORIENT_CCW);
      return verdict;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic int pick(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   function automatic req_type pair_of(int ax, int ay, int aex, int aey,
                                       int bx, int by, int bex, int bey);
      req_type pair;
      pair.a_start_x = coord_type'(ax);
      pair.a_start_y = coord_type'(ay);
      pair.a_end_x   = coord_type'(aex);
      pair.a_end_y   = coord_type'(aey);
      pair.b_start_x = coord_type'(bx);
      pair.b_start_y = coord_type'(by);
      pair.b_end_x   = coord_type'(bex);
      pair.b_end_y   = coord_type'(bey);
      return pair;
   endfunction

   // Draw one segment pair. Most draws are built to land on the colinear,
   // touching, degenerate, corner and small-box cases; the rest are raw 16-bit noise.
   function automatic req_type random_pair();
      int c[8];
      int corner[7];
      int ox, oy, dx, dy, t, src, dst;
      corner = '{-32768, -32767, -1, 0, 1, 32766, 32767};
      for (int i = 0; i < 8; i++) c[i] = pick(-32768, 32767);
      case ($urandom_range(9))
         0, 1: begin
            // full-range noise, already drawn
         end
         2, 3: begin
            // tiny grid: many colinear and touching cases
            for (int i = 0; i < 8; i++) c[i] = pick(-6, 6);
         end
         4: begin
            // all four points on one line, overlap decided by t
            ox = pick(-16000, 16000);
            oy = pick(-16000, 16000);
            dx = pick(-1000, 1000);
            dy = pick(-1000, 1000);
            for (int k = 0; k < 4; k++) begin
               t = pick(-10, 10);
               c[2*k]   = ox + t * dx;
               c[2*k+1] = oy + t * dy;
            end
         end
         5: begin
            // B starts on A's line, inside or just past its ends
            ox = pick(-16000, 16000);
            oy = pick(-16000, 16000);
            dx = pick(-2000, 2000);
            dy = pick(-2000, 2000);
            t  = pick(-2, 8);
            c[0] = ox;
            c[1] = oy;
            c[2] = ox + 6 * dx;
            c[3] = oy + 6 * dy;
            c[4] = ox + t * dx;
            c[5] = oy + t * dy;
         end
         6: begin
            // corners of the coordinate range
            for (int i = 0; i < 8; i++) begin
               if ($urandom_range(3) != 0) c[i] = corner[$urandom_range(6)];
            end
         end
         7: begin
            // degenerate point segments: A, B, both or neither
            if ($urandom_range(1) == 1) for (int i = 0; i < 8; i++) c[i] = pick(-6, 6);
            if ($urandom_range(2) != 1) begin
               c[2] = c[0];
               c[3] = c[1];
            end
            if ($urandom_range(2) != 0) begin
               c[6] = c[4];
               c[7] = c[5];
            end
         end
         8: begin
            // share an endpoint between A and B
            src = $urandom_range(1);
            dst = 2 + $urandom_range(1);
            c[2*dst]   = c[2*src];
            c[2*dst+1] = c[2*src+1];
         end
         default: begin
            // small box around the origin
            for (int i = 0; i < 8; i++) c[i] = pick(-100, 100);
         end
      endcase
      return pair_of(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
   endfunction

   task automatic offer(req_type pair);
      pair_q.insert(pair_q.size(), pair);
      pairs_queued++;
   endtask

   // Hold until every queued pair has been taken and every verdict returned.
   task automatic wait_drained();
      while (pairs_taken != pairs_queued || verdict_q.size() != 0) @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Sequence: reset, directed pairs, two random phases with a full drain
   // between them, then settle and report.
   // ------------------------------------------------------------------
   initial begin
      // extremes of the range
      offer(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
      offer(pair_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
      offer(pair_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
      offer(pair_of(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
      offer(pair_of(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767));
      offer(pair_of(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
      offer(pair_of(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
      offer(pair_of(-32768, -32767, 32767, 32767, -32767, -32768, 32767, 32766));
      // plain crossing, both turn directions
      offer(pair_of(0, 0, 4, 4, 0, 4, 4, 0));
      offer(pair_of(0, 0, 4, 4, 4, 0, 0, 4));
      // parallel apart
      offer(pair_of(0, 0, 4, 0, 0, 1, 4, 1));
      // colinear: overlap, disjoint, touching at one end, vertical overlap
      offer(pair_of(0, 0, 4, 0, 2, 0, 6, 0));
      offer(pair_of(0, 0, 2, 0, 3, 0, 5, 0));
      offer(pair_of(0, 0, 2, 0, 2, 0, 5, 0));
      offer(pair_of(3, -5, 3, 5, 3, 2, 3, 9));
      // T junction and near miss
      offer(pair_of(0, 0, 4, 0, 2, 0, 2, 5));
      offer(pair_of(0, 0, 4, 0, 2, 1, 2, 5));
      // degenerate segments: point on segment, point off, point B on A, coinciding, apart
      offer(pair_of(1, 1, 1, 1, 0, 0, 2, 2));
      offer(pair_of(1, 2, 1, 2, 0, 0, 2, 2));
      offer(pair_of(0, 0, 3, 3, 2, 2, 2, 2));
      offer(pair_of(5, -7, 5, -7, 5, -7, 5, -7));
      offer(pair_of(5, -7, 5, -7, -5, 7, -5, 7));

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // sender pause: let the directed pairs fully drain first
      wait_drained();
      for (int i = 0; i < RANDOM_PHASE; i++) offer(random_pair());
      wait_drained();
      for (int i = 0; i < RANDOM_PHASE; i++) offer(random_pair());
      wait_drained();

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Driver: change inputs on the falling edge. Advance to the next pair
   // only once the current one has transferred; send in bursts with gaps.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pair_q.size() > 0) begin
            req_data  <= pair_q.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(48, 1);
               gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 1);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: stall on a pattern of its own. Twice during the run, hold
   // rsp_ready low for a long stretch so the pipeline fills and pushes back.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (holds_done < 2 && verdicts_seen >= (holds_done + 1) * HOLD_SPACING) begin
         holds_done++;
         hold_left = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (stretch_left == 0) begin
            rx_mode      = rx_mode_type'($urandom_range(3));
            stretch_left = $urandom_range(64, 8);
         end
         stretch_left--;
         case (rx_mode)
            RX_OPEN:   rsp_ready <= 1'b1;
            RX_MOSTLY: rsp_ready <= ($urandom_range(3) != 0);
            RX_SPARSE: rsp_ready <= ($urandom_range(3) == 0);
            default:   rsp_ready <= ~rsp_ready;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Monitor: sample on the rising edge. Predict on each request transfer,
   // check each response transfer against the oldest pending verdict.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            verdict_q.insert(verdict_q.size(), judge_segments(req_data));
            pairs_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            verdicts_seen++;
            if (verdict_q.size() == 0) begin
               $display("%0t unexpected response: expected none, actual crossing=%0b dir=%0b",
                        $time, rsp_data.crossing, rsp_data.direction_down);
               mismatch_count++;
            end else begin
               verdict_head = verdict_q.pop_front();
               if (rsp_data.crossing !== verdict_head.crossing) begin
                  $display("%0t crossing mismatch: expected %0b actual %0b",
                           $time, verdict_head.crossing, rsp_data.crossing);
                  mismatch_count++;
               end
               if (rsp_data.direction_down !== verdict_head.direction_down) begin
                  $display("%0t direction_down mismatch: expected %0b actual %0b",
                           $time, verdict_head.direction_down, rsp_data.direction_down);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Watchdog: drop the run if it stalls.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout after %0d cycles, %0d verdicts pending",
                  $time, cycle_count, verdict_q.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule
